>>> design/mtst_pkg.sv
package mtst_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // command codes; code 3 decodes as a read
    localparam logic [1:0] CMD_TOGGLE = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_REMOVED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_CLEARED  = 3'd3;
    localparam logic [2:0] ST_READ_OK  = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;

    // read pointer operations
    localparam logic [2:0] PTR_HOLD  = 3'd0;
    localparam logic [2:0] PTR_ZERO  = 3'd1;
    localparam logic [2:0] PTR_INC   = 3'd2;
    localparam logic [2:0] PTR_INDEX = 3'd3;
    localparam logic [2:0] PTR_LAST  = 3'd4;

    // table write operations
    localparam logic [1:0] WR_NONE   = 2'd0;
    localparam logic [1:0] WR_APPEND = 2'd1;
    localparam logic [1:0] WR_MOVE   = 2'd2;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] col;
        logic signed [15:0] row;
        logic               half;
        logic [7:0]         glyph;
        logic [7:0]         index;
    } t_in;

    typedef struct packed {
        logic [2:0]         status;
        logic [CNT_W-1:0]   live_count;
        logic signed [15:0] out_col;
        logic signed [15:0] out_row;
        logic               out_half;
        logic [7:0]         out_glyph;
    } t_out;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic        half;
        logic [7:0]  glyph;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic [2:0] ptr_op;
        logic       mark_hit;
        logic [1:0] wr_op;
        logic       clear;
        logic       emit;
        logic [2:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       match;
        logic       at_last;
        logic       empty;
        logic       full;
        logic       idx_ok;
    } t_dp_stat;

endpackage

>>> design/mtst_ram.sv
module mtst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mtst_datapath.sv
module mtst_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mtst_pkg::t_in      i_item,
    input  mtst_pkg::t_dp_cmd  i_cmd,
    output mtst_pkg::t_dp_stat o_stat,
    output logic               o_result_valid,
    output mtst_pkg::t_out     o_result
);
    import mtst_pkg::*;

    t_in              r_req;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ADDR_W-1:0] r_hit;
    logic             r_valid;
    t_out             r_out, n_out;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    t_entry            wdata;
    t_entry            rdata;
    t_entry            key;

    assign key = '{col: r_req.col, row: r_req.row, half: r_req.half, glyph: r_req.glyph};

    // RAM read address is the next pointer, so rdata holds mem[r_ptr] unless that address was just written
    mtst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_ptr),
        .o_rdata (rdata)
    );

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_ZERO:  n_ptr = '0;
            PTR_INC:   n_ptr = r_ptr + ADDR_W'(1);
            PTR_INDEX: n_ptr = ADDR_W'(r_req.index);
            PTR_LAST:  n_ptr = ADDR_W'(r_count - CNT_W'(1));
            default:   n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        we    = (i_cmd.wr_op != WR_NONE);
        waddr = (i_cmd.wr_op == WR_APPEND) ? ADDR_W'(r_count) : r_hit;
        wdata = (i_cmd.wr_op == WR_APPEND) ? key : rdata;
    end

    always_comb begin
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.wr_op == WR_APPEND) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.wr_op == WR_MOVE) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.status     = i_cmd.status;
        n_out.live_count = n_count;
        if (i_cmd.status == ST_READ_OK) begin
            n_out.out_col   = rdata.col;
            n_out.out_row   = rdata.row;
            n_out.out_half  = rdata.half;
            n_out.out_glyph = rdata.glyph;
        end
    end

    always_comb begin
        o_stat.cmd     = r_req.cmd;
        o_stat.match   = (rdata.col == r_req.col) && (rdata.row == r_req.row)
                         && (rdata.half == r_req.half);
        o_stat.at_last = (CNT_W'(r_ptr) == r_count - CNT_W'(1));
        o_stat.empty   = (r_count == '0);
        o_stat.full    = (r_count >= CNT_W'(CAPACITY));
        o_stat.idx_ok  = ({1'b0, r_req.index} < 9'(r_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        if (i_cmd.load) begin
            r_req <= i_item;
        end
        if (i_cmd.mark_hit) begin
            r_hit <= r_ptr;
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

endmodule

>>> design/mtst_ctrl.sv
module mtst_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  mtst_pkg::t_dp_stat i_stat,
    output mtst_pkg::t_dp_cmd  o_cmd
);
    import mtst_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_MOVE     = 3'd3;
    localparam logic [2:0] S_RD_WAIT  = 3'd4;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.cmd)
                    CMD_TOGGLE: begin
                        if (i_stat.empty) begin
                            o_cmd.wr_op  = WR_APPEND;
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_INSERTED;
                            n_state      = S_IDLE;
                        end else begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_SCAN;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.clear  = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_CLEARED;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.ptr_op = PTR_INDEX;
                            n_state      = S_RD_WAIT;
                        end else begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.status = ST_RANGE;
                            n_state      = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    // hit: fetch the last entry to fill the hole
                    o_cmd.mark_hit = 1'b1;
                    o_cmd.ptr_op   = PTR_LAST;
                    n_state        = S_MOVE;
                end else if (i_stat.at_last) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.wr_op  = WR_APPEND;
                        o_cmd.status = ST_INSERTED;
                    end
                end else begin
                    o_cmd.ptr_op = PTR_INC;
                end
            end
            S_MOVE: begin
                o_cmd.wr_op  = WR_MOVE;
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_REMOVED;
                n_state      = S_IDLE;
            end
            S_RD_WAIT: begin
                o_cmd.emit   = 1'b1;
                o_cmd.status = ST_READ_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

>>> design/marker_toggle_set_table_unit.sv
// Marker set table: up to CAPACITY markers keyed by (col, row, half), each
// with a glyph byte, kept packed at table positions 0 .. count-1.
//
// Command channel: drive i_item and raise start; the beat is taken on the
// rising edge where start is high and busy is low. busy stays high until
// the command has finished its table work.
// Result channel: o_result_valid pulses for one cycle with o_result; the
// receiver must take it then, there is no backpressure. Exactly one result
// beat comes back for every command beat.
//
// Clear and a read past count finish in the dispatch state; a read goes
// on to a wait state for the entry RAM. A toggle on a non-empty table
// runs the key search, which reads the entry RAM one entry per cycle;
// a removal adds one read of the last entry before the swap write. A new
// command can be taken in the cycle its result is shown, since the
// result sits in its own register.
// Reset (synchronous, active low) empties the table and idles the
// controller; the entry RAM is not cleared, only the live count.
module marker_toggle_set_table_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  mtst_pkg::t_in   i_item,
    output logic            o_result_valid,
    output mtst_pkg::t_out  o_result
);
    import mtst_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mtst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    mtst_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // an accepted command keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // results are never on consecutive cycles
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    // live count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_result.live_count <= CNT_W'(CAPACITY)))
        else $error("live count beyond capacity");

    // data fields are zero unless the result is a good read
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status != ST_READ_OK))
        |-> (o_result.out_col == '0 && o_result.out_row == '0
             && o_result.out_half == 1'b0 && o_result.out_glyph == '0))
        else $error("nonzero data on a non-read result");

endmodule

>>> tb/marker_table_monitor.sv
module marker_table_monitor (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_busy,
    input  mtst_pkg::t_in   i_item,
    input  logic            i_result_valid,
    input  mtst_pkg::t_out  i_result,
    output int              o_mismatches,
    output int              o_outstanding
);
    import mtst_pkg::*;

    // shadow copy of the marker table
    t_entry marker_store [CAPACITY];
    int     marker_count;
    t_out   expected_results [$];

    initial o_mismatches = 0;
    initial o_outstanding = 0;

    // applies one command to the shadow table, returns the result beat it causes
    function automatic t_out apply_command(t_in c);
        t_out r;
        int   slot;
        bit   hit;
        r = '0;
        hit = 1'b0;
        slot = 0;
        case (c.cmd)
            CMD_TOGGLE: begin
                for (int i = 0; i < marker_count; i++) begin
                    if (!hit && marker_store[i].col == c.col && marker_store[i].row == c.row
                        && marker_store[i].half == c.half) begin
                        hit = 1'b1;
                        slot = i;
                    end
                end
                if (hit) begin
                    // swap-remove: last live entry fills the hole
                    marker_store[slot] = marker_store[marker_count - 1];
                    marker_count--;
                    r.status = ST_REMOVED;
                end else if (marker_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    marker_store[marker_count] = '{col: c.col, row: c.row, half: c.half,
                                                   glyph: c.glyph};
                    marker_count++;
                    r.status = ST_INSERTED;
                end
            end
            CMD_CLEAR: begin
                marker_count = 0;
                r.status = ST_CLEARED;
            end
            default: begin
                // read; the spare code lands here too
                if (int'(c.index) < marker_count) begin
                    r.out_col   = marker_store[c.index].col;
                    r.out_row   = marker_store[c.index].row;
                    r.out_half  = marker_store[c.index].half;
                    r.out_glyph = marker_store[c.index].glyph;
                    r.status    = ST_READ_OK;
                end else begin
                    r.status = ST_RANGE;
                end
            end
        endcase
        r.live_count = marker_count[CNT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            o_mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out exp_beat;
        if (!i_rst_n) begin
            marker_count = 0;
            expected_results.delete();
        end else begin
            if (i_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing outstanding: status %0d", i_result.status);
                    o_mismatches++;
                end else begin
                    exp_beat = expected_results.pop_front();
                    check_field("status", exp_beat.status, i_result.status);
                    check_field("live_count", exp_beat.live_count, i_result.live_count);
                    check_field("out_col", exp_beat.out_col, i_result.out_col);
                    check_field("out_row", exp_beat.out_row, i_result.out_row);
                    check_field("out_half", exp_beat.out_half, i_result.out_half);
                    check_field("out_glyph", exp_beat.out_glyph, i_result.out_glyph);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_command(i_item));
        end
        o_outstanding = expected_results.size();
    end

endmodule

>>> tb/testbench.sv
module testbench;
    import mtst_pkg::*;

    // spare command code, decoded by the block as a read
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_BEATS = 1600;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_result_valid;
    t_out o_result;
    int   mismatches;
    int   outstanding;

    int   beats_sent;
    bit   quiet;        // when set, commands go back to back

    marker_toggle_set_table_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // watches both channels, keeps the shadow table and scores every result beat
    marker_table_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_item         (i_item),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop in case the block hangs
    initial begin
        #30_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // One command beat. The gap before it is drawn per beat; in quiet stretches
    // start stays high across beats so the next command follows at once.
    // busy is sampled right after the edge, i.e. its value at that edge.
    task automatic issue(input logic [1:0] cmd, input logic [15:0] col,
                         input logic [15:0] row, input logic half,
                         input logic [7:0] glyph, input logic [7:0] index);
        int gap;
        if (beats_sent % 48 == 0)
            quiet = ($urandom_range(0, 3) == 0);
        gap = quiet ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= '{cmd: cmd, col: col, row: row, half: half, glyph: glyph, index: index};
        do @(posedge i_clk); while (busy);
        beats_sent++;
    endtask

    // toggle; the index field is don't-care, so it carries noise
    task automatic toggle(input logic [15:0] col, input logic [15:0] row,
                          input logic half, input logic [7:0] glyph);
        issue(CMD_TOGGLE, col, row, half, glyph, 8'($urandom));
    endtask

    // read, with don't-care key fields as noise; the spare code is used now and then
    task automatic read_at(input logic [7:0] index);
        logic [1:0] code;
        code = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_READ;
        issue(code, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom), index);
    endtask

    task automatic clear_all();
        issue(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom),
              8'($urandom));
    endtask

    // Small key pool so toggles hit often: the table stays short and
    // insert/remove/swap all get plenty of traffic.
    task automatic churn_phase(input int n);
        logic [15:0] pool_col [4];
        logic [15:0] pool_row [4];
        int pick;
        for (int i = 0; i < 4; i++) begin
            pool_col[i] = 16'($urandom);
            pool_row[i] = 16'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                toggle(pool_col[$urandom_range(0, 3)], pool_row[$urandom_range(0, 3)],
                       1'($urandom), 8'($urandom));
            else if (pick < 65)
                toggle(16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
            else if (pick < 97)
                read_at(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24)));
            else
                clear_all();
        end
    endtask

    // Fill to capacity with distinct keys (column stepped from a random base),
    // then work the full table: removals, re-inserts, ignored inserts and reads
    // at any index, with the search running over the whole table.
    task automatic fill_phase();
        logic [15:0] base_col;
        logic [15:0] fill_row;
        int k;
        int pick;
        base_col = 16'($urandom);
        fill_row = 16'($urandom);
        clear_all();
        for (int i = 0; i < CAPACITY; i++) begin
            toggle(base_col + 16'(i), fill_row, 1'(i), 8'($urandom));
            if (i % 32 == 31)
                read_at(8'($urandom));
        end
        for (int i = 0; i < 80; i++) begin
            pick = $urandom_range(0, 99);
            k = $urandom_range(0, CAPACITY + 43);
            if (pick < 45)
                toggle(base_col + 16'(k), fill_row, 1'(k), 8'($urandom));
            else if (pick < 75)
                read_at(8'($urandom));
            else
                toggle(16'($urandom), 16'($urandom), 1'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        beats_sent = 0;
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed part ---
        read_at(8'd0);                                  // empty table, out of range
        issue(CMD_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 8'hFF);
        toggle(16'h8000, 16'h7FFF, 1'b1, 8'hFF);        // extreme key values
        toggle(16'h8000, 16'h7FFF, 1'b0, 8'h00);        // same square, other half
        toggle(16'h7FFF, 16'h8000, 1'b1, 8'h5A);
        toggle(16'h0000, 16'h0000, 1'b0, 8'hA5);
        for (int i = 0; i < 5; i++)
            read_at(8'(i));                             // last one past count
        toggle(16'h8000, 16'h7FFF, 1'b1, 8'h00);        // removal, glyph ignored
        read_at(8'd0);                                  // last entry swapped in
        toggle(16'h0000, 16'h0000, 1'b0, 8'hFF);        // remove the swapped entry
        for (int i = 0; i < 3; i++)
            read_at(8'(i));
        toggle(16'h8000, 16'h7FFF, 1'b1, 8'h3C);        // re-insert a removed key
        clear_all();
        read_at(8'd0);                                  // cleared table reads nothing
        toggle(16'hFFFF, 16'hFFFF, 1'b1, 8'hFF);
        read_at(8'd0);
        clear_all();

        // --- random part: short-table churn alternating with full-table work ---
        while (beats_sent < RANDOM_BEATS) begin
            churn_phase(200);
            if (beats_sent < RANDOM_BEATS)
                fill_phase();
        end
        start <= 1'b0;

        // one edge so the monitor has queued the last beat before draining
        @(posedge i_clk);

        // drain: every command has exactly one result, then a short settle
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
